// ----- src/rbst_pkg.sv -----
// Shared constants for the ray versus box slab test.
package rbst_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;
  localparam logic signed [DATA_W-1:0] T_MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] T_MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
endpackage

// ----- src/ray_box_slab_test_top.sv -----
// Top level of the ray versus axis-aligned box slab test.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------
//  input   | origin_*, dir_*, box_min_*, box_max_*     | start && !busy
//  result  | hit                                       | done, one cycle
//
// One test is accepted every cycle; busy is always low. The result passes
// through one input stage, one divider cell per quotient bit (33 + FRAC_BITS
// cells), an ordering stage and the output register, which also takes the
// reduction across the axes. Reset clears only the valid line. The receiver
// cannot stall, so nothing ever holds the pipeline.
module ray_box_slab_test_top #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_min_z,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] box_max_z,
  output logic        done,
  output logic        hit
);
  localparam int DW    = rbst_pkg::DATA_W;
  localparam int AX    = rbst_pkg::AXES;
  localparam int LN    = rbst_pkg::LANES;
  localparam int NUM_W = DW + 1 + FRAC_BITS;
  localparam int SB    = NUM_W + 2;

  logic signed [DW-1:0] o_in [AX];
  logic signed [DW-1:0] d_in [AX];
  logic signed [DW-1:0] lo_in [AX];
  logic signed [DW-1:0] hi_in [AX];

  logic [DW-1:0]    rem_w [LN][NUM_W+1];
  logic [NUM_W-1:0] num_w [LN][NUM_W+1];
  logic [NUM_W-1:0] quo_w [LN][NUM_W+1];
  logic [DW-1:0]    den_w [LN][NUM_W+1];

  // Sideband line running beside the divider cells.
  logic          sb_valid [SB];
  logic          sb_zmiss [SB];
  logic [AX-1:0] sb_dz    [SB];
  logic [LN-1:0] sb_neg   [NUM_W+1];

  logic signed [DW-1:0] t_lo [AX];
  logic signed [DW-1:0] t_hi [AX];

  logic signed [DW-1:0] t_min, t_max;
  logic [AX-1:0]        dz_c;
  logic                 zmiss_c;
  logic signed [DW:0]   dif1 [AX];
  logic signed [DW:0]   dif2 [AX];

  assign busy = 1'b0;

  always_comb begin
    o_in  = '{origin_x, origin_y, origin_z};
    d_in  = '{dir_x, dir_y, dir_z};
    lo_in = '{box_min_x, box_min_y, box_min_z};
    hi_in = '{box_max_x, box_max_y, box_max_z};
    zmiss_c = 1'b0;
    for (int a = 0; a < AX; a++) begin
      dif1[a] = {lo_in[a][DW-1], lo_in[a]} - {o_in[a][DW-1], o_in[a]};
      dif2[a] = {hi_in[a][DW-1], hi_in[a]} - {o_in[a][DW-1], o_in[a]};
      dz_c[a] = (d_in[a] == '0);
      if (dz_c[a] && (o_in[a] < lo_in[a] || o_in[a] > hi_in[a])) begin
        zmiss_c = 1'b1;
      end
    end
  end

  // Input stage: differences, magnitudes and quotient signs.
  for (genvar a = 0; a < AX; a++) begin : g_in
    always_ff @(posedge clk) begin
      rem_w[2*a][0]   <= '0;
      rem_w[2*a+1][0] <= '0;
      num_w[2*a][0]   <= {1'b0, (dif1[a][DW] ? DW'(0) - dif1[a][DW-1:0] : dif1[a][DW-1:0]),
                          FRAC_BITS'(0)};
      num_w[2*a+1][0] <= {1'b0, (dif2[a][DW] ? DW'(0) - dif2[a][DW-1:0] : dif2[a][DW-1:0]),
                          FRAC_BITS'(0)};
      quo_w[2*a][0]   <= '0;
      quo_w[2*a+1][0] <= '0;
      den_w[2*a][0]   <= d_in[a][DW-1] ? DW'(0) - d_in[a] : d_in[a];
      den_w[2*a+1][0] <= d_in[a][DW-1] ? DW'(0) - d_in[a] : d_in[a];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AX; a++) begin
      sb_neg[0][2*a]   <= dif1[a][DW] != d_in[a][DW-1];
      sb_neg[0][2*a+1] <= dif2[a][DW] != d_in[a][DW-1];
    end
    sb_zmiss[0] <= zmiss_c;
    sb_dz[0]    <= dz_c;
    for (int s = 1; s < SB; s++) begin
      sb_zmiss[s] <= sb_zmiss[s-1];
      sb_dz[s]    <= sb_dz[s-1];
    end
    for (int s = 1; s <= NUM_W; s++) begin
      sb_neg[s] <= sb_neg[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SB; s++) begin
        sb_valid[s] <= 1'b0;
      end
    end else begin
      sb_valid[0] <= start && !busy;
      for (int s = 1; s < SB; s++) begin
        sb_valid[s] <= sb_valid[s-1];
      end
    end
  end

  for (genvar l = 0; l < LN; l++) begin : g_lane
    for (genvar s = 0; s < NUM_W; s++) begin : g_cell
      rbst_div_cell #(.NUM_W(NUM_W), .DEN_W(DW)) u_cell (
        .clk    (clk),
        .rem_in (rem_w[l][s]),
        .num_in (num_w[l][s]),
        .quo_in (quo_w[l][s]),
        .den_in (den_w[l][s]),
        .rem_out(rem_w[l][s+1]),
        .num_out(num_w[l][s+1]),
        .quo_out(quo_w[l][s+1]),
        .den_out(den_w[l][s+1])
      );
    end
  end

  for (genvar a = 0; a < AX; a++) begin : g_axis
    rbst_slab_order #(.NUM_W(NUM_W)) u_order (
      .clk (clk),
      .q1  (quo_w[2*a][NUM_W]),
      .q2  (quo_w[2*a+1][NUM_W]),
      .neg1(sb_neg[NUM_W][2*a]),
      .neg2(sb_neg[NUM_W][2*a+1]),
      .t_lo(t_lo[a]),
      .t_hi(t_hi[a])
    );
  end

  // Narrowing is monotone, so one final compare matches the early exit.
  always_comb begin
    t_min = rbst_pkg::T_MOST_NEG;
    t_max = rbst_pkg::T_MOST_POS;
    for (int a = 0; a < AX; a++) begin
      if (!sb_dz[SB-1][a]) begin
        if (t_lo[a] > t_min) t_min = t_lo[a];
        if (t_hi[a] < t_max) t_max = t_hi[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    hit <= !sb_zmiss[SB-1] && !(t_min > t_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sb_valid[SB-1];
    end
  end
endmodule

// ----- src/rbst_div_cell.sv -----
// One restoring division step: one quotient bit per cell, registered.
module rbst_div_cell #(
  parameter int NUM_W = rbst_pkg::DATA_W + 1 + rbst_pkg::FRAC_BITS,
  parameter int DEN_W = rbst_pkg::DATA_W
) (
  input  logic             clk,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [NUM_W-1:0] quo_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [DEN_W-1:0] rem_out,
  output logic [NUM_W-1:0] num_out,
  output logic [NUM_W-1:0] quo_out,
  output logic [DEN_W-1:0] den_out
);
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem_in, num_in[NUM_W-1]};
    diff  = trial - {1'b0, den_in};
    ge    = trial >= {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    rem_out <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_out <= {num_in[NUM_W-2:0], 1'b0};
    quo_out <= {quo_in[NUM_W-2:0], ge};
    den_out <= den_in;
  end
endmodule

// ----- src/rbst_slab_order.sv -----
// Saturates the two slab distances of one axis and orders them.
module rbst_slab_order #(
  parameter int NUM_W = rbst_pkg::DATA_W + 1 + rbst_pkg::FRAC_BITS
) (
  input  logic                               clk,
  input  logic [NUM_W-1:0]                   q1,
  input  logic [NUM_W-1:0]                   q2,
  input  logic                               neg1,
  input  logic                               neg2,
  output logic signed [rbst_pkg::DATA_W-1:0] t_lo,
  output logic signed [rbst_pkg::DATA_W-1:0] t_hi
);
  localparam int DW = rbst_pkg::DATA_W;
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(1) << (DW - 1);
  localparam logic [NUM_W-1:0] POS_LIM = NEG_LIM - NUM_W'(1);

  logic signed [DW-1:0] s1, s2;

  function automatic logic signed [DW-1:0] sat(input logic [NUM_W-1:0] q, input logic neg);
    logic signed [DW-1:0] r;
    if (neg) begin
      r = (q > NEG_LIM) ? rbst_pkg::T_MOST_NEG : -$signed(q[DW-1:0]);
    end else begin
      r = (q > POS_LIM) ? rbst_pkg::T_MOST_POS : $signed(q[DW-1:0]);
    end
    return r;
  endfunction

  always_comb begin
    s1 = sat(q1, neg1);
    s2 = sat(q2, neg2);
  end

  always_ff @(posedge clk) begin
    if (s1 > s2) begin
      t_lo <= s2;
      t_hi <= s1;
    end else begin
      t_lo <= s1;
      t_hi <= s2;
    end
  end
endmodule

// ----- tb/sv/ray_box_slab_test_top_tb.sv -----
// Self-checking testbench for the ray versus axis-aligned box slab test.
`timescale 1ns / 1ps

module ray_box_slab_test_top_tb;
  localparam int LATENCY  = rbst_pkg::FRAC_BITS + 36;
  localparam int WD_LIMIT = 20 * LATENCY + 2000;
  localparam int N_RANDOM = 1250;

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] lo  [3];
    logic signed [31:0] hi  [3];
  } ray_box_t;

  // Directed row: known = 1 when the expected flag is typed in.
  typedef struct {
    ray_box_t rb;
    bit       known;
    bit       hit;
  } test_row_t;

  logic clk, rst, start;
  logic busy, done, hit;
  logic signed [31:0] org_d [3];
  logic signed [31:0] dir_d [3];
  logic signed [31:0] lo_d  [3];
  logic signed [31:0] hi_d  [3];

  bit      hit_q [$];
  int      errors;
  int      n_sent, n_checked, n_hits;
  int      idle_cnt;
  bit      finished;
  test_row_t rows [$];

  ray_box_slab_test_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .origin_x(org_d[0]), .origin_y(org_d[1]), .origin_z(org_d[2]),
    .dir_x(dir_d[0]), .dir_y(dir_d[1]), .dir_z(dir_d[2]),
    .box_min_x(lo_d[0]), .box_min_y(lo_d[1]), .box_min_z(lo_d[2]),
    .box_max_x(hi_d[0]), .box_max_y(hi_d[1]), .box_max_z(hi_d[2]),
    .done(done), .hit(hit)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Fixed-point quotient, truncated toward zero and saturated to 32 bits.
  function automatic logic signed [31:0] slab_quot(logic signed [32:0] num,
                                                   logic signed [31:0] den);
    logic        neg;
    logic [32:0] mn;
    logic [31:0] md;
    logic [63:0] q;
    neg = (num < 0) != (den < 0);
    mn  = (num < 0) ? -num : num;
    md  = (den < 0) ? -den : den;
    q   = ({31'd0, mn} << rbst_pkg::FRAC_BITS) / {32'd0, md};
    if (neg) begin
      if (q > 64'h8000_0000) return rbst_pkg::T_MOST_NEG;
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) return rbst_pkg::T_MOST_POS;
    return q[31:0];
  endfunction

  function automatic bit predict_hit(ray_box_t rb);
    logic signed [31:0] tmin, tmax, t1, t2, tt;
    logic signed [32:0] o, l, h;
    tmin = rbst_pkg::T_MOST_NEG;
    tmax = rbst_pkg::T_MOST_POS;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      o = rb.org[a]; l = rb.lo[a]; h = rb.hi[a];
      if (rb.dir[a] == 0) begin
        if (o < l || o > h) return 1'b0;
      end else begin
        t1 = slab_quot(l - o, rb.dir[a]);
        t2 = slab_quot(h - o, rb.dir[a]);
        if (t1 > t2) begin
          tt = t1; t1 = t2; t2 = tt;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic signed [31:0] rnd32();
    return $urandom;
  endfunction

  // Small coordinates, sometimes full range or an extreme.
  function automatic logic signed [31:0] coord();
    case ($urandom_range(0, 9))
      0: return rnd32();
      1: return ($urandom_range(0, 1)) ? rbst_pkg::T_MOST_POS : rbst_pkg::T_MOST_NEG;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic ray_box_t random_ray_box();
    ray_box_t rb;
    logic signed [31:0] a, b;
    for (int i = 0; i < rbst_pkg::AXES; i++) begin
      rb.org[i] = coord();
      case ($urandom_range(0, 7))
        0: rb.dir[i] = 0;
        1: rb.dir[i] = rnd32();
        2: rb.dir[i] = $signed($urandom_range(0, 64)) - 32;
        default: rb.dir[i] = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      endcase
      a = coord(); b = coord();
      // Mostly well-formed boxes; sometimes corners swapped.
      if ((a > b) != ($urandom_range(0, 9) == 0)) begin
        rb.lo[i] = b; rb.hi[i] = a;
      end else begin
        rb.lo[i] = a; rb.hi[i] = b;
      end
    end
    return rb;
  endfunction

  function automatic ray_box_t make_rb(logic signed [31:0] o, logic signed [31:0] d,
                                       logic signed [31:0] l, logic signed [31:0] h);
    ray_box_t rb;
    for (int i = 0; i < rbst_pkg::AXES; i++) begin
      rb.org[i] = o; rb.dir[i] = d; rb.lo[i] = l; rb.hi[i] = h;
    end
    return rb;
  endfunction

  task automatic add_row(ray_box_t rb, bit known, bit h);
    test_row_t r;
    r.rb = rb; r.known = known; r.hit = h;
    rows.push_back(r);
  endtask

  task automatic build_rows();
    ray_box_t rb;
    add_row(make_rb(0, 32'sh10000, -32'sh10000, 32'sh10000), 1, 1);
    add_row(make_rb(0, 0, -32'sh10000, 32'sh10000), 1, 1);
    add_row(make_rb(32'sh30000, 0, -32'sh10000, 32'sh10000), 1, 0);
    add_row(make_rb(-32'sh30000, 0, -32'sh10000, 32'sh10000), 1, 0);
    add_row(make_rb(0, 0, 32'sh10000, -32'sh10000), 1, 0);      // swapped, zero dir
    add_row(make_rb(0, 32'sh10000, 32'sh10000, -32'sh10000), 0, 0); // swapped
    add_row(make_rb(rbst_pkg::T_MOST_NEG, 1, rbst_pkg::T_MOST_POS,
                    rbst_pkg::T_MOST_POS), 0, 0); // saturation
    add_row(make_rb(rbst_pkg::T_MOST_POS, -1, rbst_pkg::T_MOST_NEG,
                    rbst_pkg::T_MOST_NEG), 0, 0);
    add_row(make_rb(rbst_pkg::T_MOST_NEG, rbst_pkg::T_MOST_NEG, rbst_pkg::T_MOST_NEG,
                    rbst_pkg::T_MOST_POS), 0, 0);
    add_row(make_rb(rbst_pkg::T_MOST_POS, rbst_pkg::T_MOST_POS, rbst_pkg::T_MOST_NEG,
                    rbst_pkg::T_MOST_POS), 0, 0);
    add_row(make_rb(32'sh50000, 32'sh10000, -32'sh10000, 32'sh10000), 0, 0); // behind
    add_row(make_rb(rbst_pkg::T_MOST_POS, 0, rbst_pkg::T_MOST_POS,
                    rbst_pkg::T_MOST_POS), 1, 1);
    add_row(make_rb(rbst_pkg::T_MOST_NEG, 0, rbst_pkg::T_MOST_NEG,
                    rbst_pkg::T_MOST_NEG), 1, 1);
    add_row(make_rb(32'shFFFF_FFFF, 32'shFFFF_FFFF, 0, 0), 0, 0);
    rb = make_rb(0, 32'sh10000, -32'sh10000, 32'sh10000);
    rb.org[1] = 32'sh40000; rb.dir[1] = 32'sh10000;
    rb.lo[2] = 32'sh80000; rb.hi[2] = 32'sh90000; rb.dir[2] = 32'sh100;
    add_row(rb, 0, 0);
  endtask

  task automatic drive(ray_box_t rb);
    for (int i = 0; i < rbst_pkg::AXES; i++) begin
      org_d[i] <= rb.org[i]; dir_d[i] <= rb.dir[i];
      lo_d[i]  <= rb.lo[i];  hi_d[i]  <= rb.hi[i];
    end
  endtask

  // One transaction; gaps between transactions when gaps_on is set.
  task automatic send(ray_box_t rb, bit known, bit h, bit gaps_on);
    bit exp_hit;
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      @(negedge clk);
    end
    drive(rb);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_hit = predict_hit(rb);
    if (known && exp_hit != h)
      report_mismatch($sformatf("table row %0d: predictor %0b, table %0b", n_sent, exp_hit, h));
    hit_q.push_back(known ? h : exp_hit);
    n_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (hit_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        if (hit !== hit_q[0])
          report_mismatch($sformatf("hit %b, expected %b", hit, hit_q[0]));
        n_hits += hit_q[0];
        void'(hit_q.pop_front());
        n_checked++;
      end
    end
  end

  // Watchdog on cycles with no accepted transaction at either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT && !finished) begin
      $display("watchdog expired");
      $display("ray_box_slab_test_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1; start = 1'b0;
    errors = 0; n_sent = 0; n_checked = 0; n_hits = 0; idle_cnt = 0; finished = 0;
    for (int i = 0; i < rbst_pkg::AXES; i++) begin
      org_d[i] = 0; dir_d[i] = 0; lo_d[i] = 0; hi_d[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    build_rows();
    foreach (rows[i]) send(rows[i].rb, rows[i].known, rows[i].hit, 1);
    start <= 1'b0;
    // Hold the sender off until the pipeline has drained.
    while (hit_q.size() != 0) @(negedge clk);
    for (int n = 0; n < N_RANDOM; n++)
      send(random_ray_box(), 0, 0, !(n >= 300 && n < 600));
    start <= 1'b0;
    while (hit_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    finished = 1;
    $display("Sent %0d ray/box tests (directed extremes, zero directions, swapped corners,",
             n_sent);
    $display("saturating quotients, random rays); %0d results checked, %0d hits.",
             n_checked, n_hits);
    if (errors == 0) begin
      $display("ray_box_slab_test_top_tb OK");
    end else begin
      $display("ray_box_slab_test_top_tb NOT OK");
    end
    $finish;
  end
endmodule
